### hdl/sorted_priority_queue_unit_defines.svh
// Assertion macros used by the sorted priority queue datapath.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");

// Next-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");

`endif

### hdl/spq_pkg.sv
// Package for the sorted priority queue: field widths, codes and the
// controller/datapath interface types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int RANK_W   = 16;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int ENTRY_W  = RANK_W + TAG_W;
   localparam int OP_W     = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
   localparam logic [OP_W-1:0] OP_REJECT     = 4'd2;
   localparam logic [OP_W-1:0] OP_INS_READ   = 4'd3;
   localparam logic [OP_W-1:0] OP_INS_SHIFT  = 4'd4;
   localparam logic [OP_W-1:0] OP_INS_PLACE  = 4'd5;
   localparam logic [OP_W-1:0] OP_REM_READ   = 4'd6;
   localparam logic [OP_W-1:0] OP_REM_HEAD   = 4'd7;
   localparam logic [OP_W-1:0] OP_REM_MOVE   = 4'd8;
   localparam logic [OP_W-1:0] OP_REM_FINISH = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic ptr_zero;
      logic ptr_at_count;
      logic rank_greater;
   } dp_stat_type;

endpackage

`default_nettype wire

### hdl/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg; drives datapath commands and reads datapath status.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire spq_pkg::dp_stat_type dp_stat,
   output spq_pkg::dp_cmd_type      dp_cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DECIDE    = 3'd1;
   localparam logic [2:0] ST_INS_READ  = 3'd2;
   localparam logic [2:0] ST_INS_CHECK = 3'd3;
   localparam logic [2:0] ST_REM_HEAD  = 3'd4;
   localparam logic [2:0] ST_REM_READ  = 3'd5;
   localparam logic [2:0] ST_REM_MOVE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      dp_cmd.op   = spq_pkg::OP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dp_cmd.op = spq_pkg::OP_LOAD;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!dp_stat.is_remove && dp_stat.full) begin
               dp_cmd.op = spq_pkg::OP_REJECT;
               state_in  = ST_IDLE;
            end else if (dp_stat.is_remove && dp_stat.empty) begin
               dp_cmd.op = spq_pkg::OP_REJECT;
               state_in  = ST_IDLE;
            end else if (dp_stat.is_remove) begin
               dp_cmd.op = spq_pkg::OP_REM_READ;
               state_in  = ST_REM_HEAD;
            end else begin
               state_in  = ST_INS_READ;
            end
         end
         ST_INS_READ: begin
            if (dp_stat.ptr_zero) begin
               dp_cmd.op = spq_pkg::OP_INS_PLACE;
               state_in  = ST_IDLE;
            end else begin
               dp_cmd.op = spq_pkg::OP_INS_READ;
               state_in  = ST_INS_CHECK;
            end
         end
         ST_INS_CHECK: begin
            if (dp_stat.rank_greater) begin
               dp_cmd.op = spq_pkg::OP_INS_SHIFT;
               state_in  = ST_INS_READ;
            end else begin
               dp_cmd.op = spq_pkg::OP_INS_PLACE;
               state_in  = ST_IDLE;
            end
         end
         ST_REM_HEAD: begin
            dp_cmd.op = spq_pkg::OP_REM_HEAD;
            state_in  = ST_REM_READ;
         end
         ST_REM_READ: begin
            if (dp_stat.ptr_at_count) begin
               dp_cmd.op = spq_pkg::OP_REM_FINISH;
               state_in  = ST_IDLE;
            end else begin
               dp_cmd.op = spq_pkg::OP_REM_READ;
               state_in  = ST_REM_MOVE;
            end
         end
         ST_REM_MOVE: begin
            dp_cmd.op = spq_pkg::OP_REM_MOVE;
            state_in  = ST_REM_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hdl/spq_datapath.sv
// Datapath of the sorted priority queue: entry memory, count, pointer and
// result registers. Depends on spq_pkg and sorted_priority_queue_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_unit_defines.svh"

module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire spq_pkg::dp_cmd_type                   dp_cmd,
   output spq_pkg::dp_stat_type                       dp_stat,
   input  wire logic                                  req_command,
   input  wire logic signed [spq_pkg::RANK_W-1:0]     req_rank,
   input  wire logic        [spq_pkg::TAG_W-1:0]      req_task_tag,
   output logic                                       rsp_valid,
   output logic             [spq_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed      [spq_pkg::RANK_W-1:0]     rsp_removed_rank,
   output logic             [spq_pkg::TAG_W-1:0]      rsp_removed_tag,
   output logic             [spq_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int CntW  = $clog2(DEPTH + 1);
   localparam int AddrW = $clog2(DEPTH);
   localparam int WideW = (CntW > spq_pkg::OCC_W) ? CntW : spq_pkg::OCC_W;

   logic [spq_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [spq_pkg::ENTRY_W-1:0] rd_data_ff;

   logic                              cmd_ff, cmd_in;
   logic signed [spq_pkg::RANK_W-1:0] new_rank_ff, new_rank_in;
   logic [spq_pkg::TAG_W-1:0]         new_tag_ff, new_tag_in;
   logic [CntW-1:0]                   ptr_ff, ptr_in;
   logic [CntW-1:0]                   count_ff, count_in;
   logic [CntW-1:0]                   ptr_m1;
   logic [WideW-1:0]                  count_wide;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [spq_pkg::RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic [spq_pkg::TAG_W-1:0]         rsp_tag_ff, rsp_tag_in;
   logic [spq_pkg::OCC_W-1:0]         rsp_occ_ff, rsp_occ_in;

   logic                              wr_en;
   logic [AddrW-1:0]                  wr_addr;
   logic [spq_pkg::ENTRY_W-1:0]       wr_data;
   logic                              rd_en;
   logic [AddrW-1:0]                  rd_addr;
   logic signed [spq_pkg::RANK_W-1:0] rd_rank;

   assign ptr_m1  = ptr_ff - CntW'(1);
   assign rd_rank = $signed(rd_data_ff[spq_pkg::ENTRY_W-1:spq_pkg::TAG_W]);

   assign dp_stat.is_remove    = (cmd_ff == spq_pkg::CMD_REMOVE);
   assign dp_stat.full         = (count_ff == CntW'(DEPTH));
   assign dp_stat.empty        = (count_ff == '0);
   assign dp_stat.ptr_zero     = (ptr_ff == '0);
   assign dp_stat.ptr_at_count = (ptr_ff == count_ff);
   assign dp_stat.rank_greater = (rd_rank > new_rank_ff);

   assign count_wide = WideW'(count_in);

   always_comb begin
      cmd_in        = cmd_ff;
      new_rank_in   = new_rank_ff;
      new_tag_in    = new_tag_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_tag_in    = rsp_tag_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[AddrW-1:0];
      wr_data       = rd_data_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[AddrW-1:0];
      case (dp_cmd.op)
         spq_pkg::OP_LOAD: begin
            cmd_in      = req_command;
            new_rank_in = req_rank;
            new_tag_in  = req_task_tag;
            ptr_in      = (req_command == spq_pkg::CMD_INSERT) ? count_ff : '0;
         end
         spq_pkg::OP_REJECT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = (cmd_ff == spq_pkg::CMD_INSERT) ? spq_pkg::STATUS_FULL
                                                            : spq_pkg::STATUS_EMPTY;
            rsp_rank_in   = '0;
            rsp_tag_in    = '0;
         end
         spq_pkg::OP_INS_READ: begin
            rd_en   = 1'b1;
            rd_addr = ptr_m1[AddrW-1:0];
         end
         spq_pkg::OP_INS_SHIFT: begin
            wr_en  = 1'b1;
            ptr_in = ptr_m1;
         end
         spq_pkg::OP_INS_PLACE: begin
            wr_en         = 1'b1;
            wr_data       = {new_rank_ff, new_tag_ff};
            count_in      = count_ff + CntW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = spq_pkg::STATUS_DONE;
            rsp_rank_in   = '0;
            rsp_tag_in    = '0;
         end
         spq_pkg::OP_REM_READ: begin
            rd_en = 1'b1;
         end
         spq_pkg::OP_REM_HEAD: begin
            rsp_rank_in = rd_rank;
            rsp_tag_in  = rd_data_ff[spq_pkg::TAG_W-1:0];
            ptr_in      = CntW'(1);
         end
         spq_pkg::OP_REM_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_m1[AddrW-1:0];
            ptr_in  = ptr_ff + CntW'(1);
         end
         spq_pkg::OP_REM_FINISH: begin
            count_in      = count_ff - CntW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = spq_pkg::STATUS_DONE;
         end
         default: begin
         end
      endcase
      rsp_occ_in = rsp_valid_in ? count_wide[spq_pkg::OCC_W-1:0] : rsp_occ_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      new_rank_ff   <= new_rank_in;
      new_tag_ff    <= new_tag_in;
      ptr_ff        <= ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_removed_rank = rsp_rank_ff;
   assign rsp_removed_tag  = rsp_tag_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CntW'(DEPTH))
   `SPQ_ASSERT_NEXT(a_strobe_gap, rsp_valid_ff, !rsp_valid_ff)
   `SPQ_ASSERT_NEXT(a_place_count, dp_cmd.op == spq_pkg::OP_INS_PLACE,
      count_ff == $past(count_ff) + CntW'(1))
   `SPQ_ASSERT_IMP(a_reject_full, dp_cmd.op == spq_pkg::OP_REJECT && !dp_stat.is_remove,
      dp_stat.full)

endmodule

`default_nettype wire

### hdl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A transaction is taken at a rising edge where start is high and busy is low.
// req_command selects insert (0) or remove of the head entry (1); req_rank and
// req_task_tag carry the entry for an insert. Entries are kept in ascending
// rank order in a single-port-read, single-port-write memory, and equal ranks
// leave in arrival order.
// Every transaction yields one result, shown for one cycle with rsp_valid high:
// status, removed rank and tag (zero unless a head was removed) and occupancy.
// Steps: a refused insert or remove is answered straight from the decide state.
// An insert reads and shifts the entries of higher rank one at a time from the
// tail; a remove reads the head, then moves every other entry up one place. Each
// moved entry costs one memory read and one write, done in separate states.
// busy drops in the cycle the result is shown, so the next transaction can be
// accepted then. The receiver cannot stall; results must be taken when shown.
// Reset empties the queue at once and needs no clearing pass.

module sorted_priority_queue_unit #(
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_command,
   input  wire logic signed [spq_pkg::RANK_W-1:0]     req_rank,
   input  wire logic        [spq_pkg::TAG_W-1:0]      req_task_tag,
   output logic                                       rsp_valid,
   output logic             [spq_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed      [spq_pkg::RANK_W-1:0]     rsp_removed_rank,
   output logic             [spq_pkg::TAG_W-1:0]      rsp_removed_tag,
   output logic             [spq_pkg::OCC_W-1:0]      rsp_occupancy
);

   spq_pkg::dp_cmd_type  dp_cmd;
   spq_pkg::dp_stat_type dp_stat;

   spq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .dp_stat (dp_stat),
      .dp_cmd  (dp_cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_stat          (dp_stat),
      .req_command      (req_command),
      .req_rank         (req_rank),
      .req_task_tag     (req_task_tag),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_removed_rank (rsp_removed_rank),
      .rsp_removed_tag  (rsp_removed_tag),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

`default_nettype wire
